// ----- rtl/core/rau_pkg.sv -----
// Package for the rational arithmetic unit: operation codes, status codes
// and the step codes the controller issues to the datapath. No dependencies.
`timescale 1ns / 1ps
package rau_pkg;

  localparam int unsigned WordBitsDefault = 64;

  localparam logic [2:0] KIND_ADD = 3'd0;
  localparam logic [2:0] KIND_SUB = 3'd1;
  localparam logic [2:0] KIND_MUL = 3'd2;
  localparam logic [2:0] KIND_DIV = 3'd3;
  localparam logic [2:0] KIND_NEG = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  // Steps the controller runs on the datapath for one item.
  localparam logic [3:0] S_NORM_A = 4'd0;
  localparam logic [3:0] S_NORM_B = 4'd1;
  localparam logic [3:0] S_OPER   = 4'd2;
  localparam logic [3:0] S_NORM_R = 4'd3;

endpackage

// ----- rtl/core/rau_datapath.sv -----
// Datapath of the rational arithmetic unit: operand registers, an iterative
// divider shared by gcd and reductions, and a shift-add multiplier.
// Depends on rau_pkg.
`timescale 1ns / 1ps
module rau_datapath import rau_pkg::*; #(
  parameter int unsigned WORD_BITS = WordBitsDefault
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  logic [2:0]             kind,
  input  logic [63:0]            a_num,
  input  logic [63:0]            a_den,
  input  logic [63:0]            b_num,
  input  logic [62:0]            b_den,
  input  logic [3:0]             step,
  input  logic                   step_go,
  output logic                   step_done,
  output logic [1:0]             st,
  output logic [2:0]             kind_q,
  output logic [WORD_BITS-1:0]   res_num,
  output logic [WORD_BITS-1:0]   res_den
);
  localparam int unsigned W = WORD_BITS;
  localparam int unsigned CW = $clog2(W + 1);
  localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] ONE = {{(W-1){1'b0}}, 1'b1};

  // Working registers (signed values in two's complement).
  logic [W-1:0] an, ad, bn, bd, rn, rd, g1, g2;
  logic [1:0]   stq;
  logic [2:0]   kq;

  // Iterative unsigned divider: one quotient bit per cycle.
  logic         dv_busy;
  logic [CW-1:0] dv_cnt;
  logic [W-1:0] dv_q, dv_r, dv_d;
  logic [W:0]   dv_trial;
  assign dv_trial = {dv_r, dv_q[W-1]} - {1'b0, dv_d};

  // Iterative multiplier on magnitudes: 2W-bit product, one bit per cycle.
  logic          mu_busy;
  logic [CW-1:0] mu_cnt;
  logic [2*W-1:0] mu_acc;
  logic [W-1:0]  mu_a, mu_b;

  function automatic logic [W-1:0] magf(input logic [W-1:0] x);
    magf = x[W-1] ? (~x + ONE) : x;
  endfunction

  // Micro-sequencer inside one step: sub-phase and gcd registers.
  logic [4:0]   ph;
  logic [W-1:0] gx, gy;

  // Normalizer sub-operation over (rn, rd) with gcd.
  // Phase encodings within a step.
  localparam logic [4:0] P_START = 5'd0;
  localparam logic [4:0] P_GCD   = 5'd1;
  localparam logic [4:0] P_DIVN  = 5'd2;
  localparam logic [4:0] P_DIVD  = 5'd3;
  localparam logic [4:0] P_FIN   = 5'd4;
  localparam logic [4:0] P_G1    = 5'd5;
  localparam logic [4:0] P_G2    = 5'd6;
  localparam logic [4:0] P_Q1    = 5'd7;
  localparam logic [4:0] P_Q2    = 5'd8;
  localparam logic [4:0] P_Q3    = 5'd9;
  localparam logic [4:0] P_Q4    = 5'd10;
  localparam logic [4:0] P_M1    = 5'd11;
  localparam logic [4:0] P_M2    = 5'd12;
  localparam logic [4:0] P_M3    = 5'd13;
  localparam logic [4:0] P_M4    = 5'd14;
  localparam logic [4:0] P_ADD   = 5'd15;
  localparam logic [4:0] P_WAIT  = 5'd16;

  // Multiply result check: signed product of magnitudes within W bits.
  logic         mu_neg;
  logic         mu_ovf;
  logic [W-1:0] mu_res;
  always_comb begin
    mu_ovf = 1'b0;
    if (mu_acc[2*W-1:W] != '0) mu_ovf = 1'b1;
    else if (mu_neg) mu_ovf = mu_acc[W-1] && (mu_acc[W-2:0] != '0);
    else mu_ovf = mu_acc[W-1];
    mu_res = mu_neg ? (~mu_acc[W-1:0] + ONE) : mu_acc[W-1:0];
  end

  // Temporaries: t1 holds a reduced operand or the first add product.
  logic [W-1:0] t1, adg, bdg;
  logic [W:0]   sum;
  assign sum = {t1[W-1], t1} + {mu_res[W-1], mu_res};

  logic busy_any;
  assign busy_any = dv_busy || mu_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_busy <= 1'b0;
      mu_busy <= 1'b0;
      step_done <= 1'b0;
      ph <= P_START;
    end else begin
      step_done <= 1'b0;
      if (dv_busy) begin
        dv_q <= {dv_q[W-2:0], ~dv_trial[W]};
        dv_r <= dv_trial[W] ? {dv_r[W-2:0], dv_q[W-1]} : dv_trial[W-1:0];
        dv_cnt <= dv_cnt - 1'b1;
        if (dv_cnt == CW'(1)) dv_busy <= 1'b0;
      end
      if (mu_busy) begin
        if (mu_b[0]) mu_acc <= mu_acc + ({{W{1'b0}}, mu_a} << (CW'(W) - mu_cnt));
        mu_b <= mu_b >> 1;
        mu_cnt <= mu_cnt - 1'b1;
        if (mu_cnt == CW'(1)) mu_busy <= 1'b0;
      end
      if (load) begin
        an <= W'(a_num); ad <= W'(a_den); bn <= W'(b_num);
        bd <= {1'b0, b_den[W-2:0]};
        kq <= kind;
        stq <= ST_OK;
        ph <= P_START;
      end else if (step_go && !busy_any && !step_done) begin
        unique case (step)
          S_NORM_A, S_NORM_B, S_NORM_R: begin
            unique case (ph)
              P_START: begin
                if (step == S_NORM_A) begin rn <= an; rd <= ad; end
                else if (step == S_NORM_B) begin rn <= bn; rd <= bd; end
                ph <= P_G1;
              end
              P_G1: begin
                if (rd == '0) begin
                  stq <= ST_DIV0; ph <= P_START; step_done <= 1'b1;
                end else if (rn == '0) begin
                  rd <= ONE; ph <= P_FIN;
                end else if (rd[W-1]) begin
                  if (rd == WMIN || rn == WMIN) begin
                    stq <= ST_OVF; ph <= P_START; step_done <= 1'b1;
                  end else begin
                    rn <= ~rn + ONE; rd <= ~rd + ONE; ph <= P_G2;
                  end
                end else ph <= P_G2;
              end
              P_G2: begin
                gx <= magf(rn); gy <= rd; ph <= P_GCD;
              end
              P_GCD: begin
                // Euclid: each round one remainder through the divider.
                if (gy == '0) begin
                  g1 <= gx; ph <= P_DIVN;
                  dv_d <= gx; dv_q <= magf(rn); dv_r <= '0;
                  dv_cnt <= CW'(W); dv_busy <= 1'b1;
                end else begin
                  dv_d <= gy; dv_q <= gx; dv_r <= '0;
                  dv_cnt <= CW'(W); dv_busy <= 1'b1; ph <= P_WAIT;
                end
              end
              P_WAIT: begin
                gx <= gy; gy <= dv_r; ph <= P_GCD;
              end
              P_DIVN: begin
                rn <= rn[W-1] ? (~dv_q + ONE) : dv_q;
                dv_d <= g1; dv_q <= rd; dv_r <= '0;
                dv_cnt <= CW'(W); dv_busy <= 1'b1; ph <= P_DIVD;
              end
              P_DIVD: begin
                rd <= dv_q; ph <= P_FIN;
              end
              default: begin
                if (step == S_NORM_A) begin an <= rn; ad <= rd; end
                else if (step == S_NORM_B) begin bn <= rn; bd <= rd; end
                ph <= P_START; step_done <= 1'b1;
              end
            endcase
          end
          default: begin
            // Operation step.
            unique case (ph)
              P_START: begin
                priority if (kq == KIND_SUB && bn == WMIN) begin
                  stq <= ST_OVF; step_done <= 1'b1;
                end else if (kq == KIND_SUB) begin
                  bn <= ~bn + ONE; kq <= KIND_ADD;
                end else if (kq == KIND_NEG) begin
                  if (an == WMIN) stq <= ST_OVF;
                  else begin rn <= ~an + ONE; rd <= ad; end
                  step_done <= 1'b1;
                end else if (kq == KIND_DIV) begin
                  if (bn == '0) stq <= ST_DIV0;
                  else if (bn[W-1] && (bn == WMIN || bd == WMIN)) stq <= ST_OVF;
                  else if (bn[W-1]) begin
                    bn <= ~bd + ONE; bd <= ~bn + ONE; kq <= KIND_MUL;
                  end else begin
                    bn <= bd; bd <= bn; kq <= KIND_MUL;
                  end
                  if (bn == '0 || (bn[W-1] && (bn == WMIN || bd == WMIN)))
                    step_done <= 1'b1;
                end else if (kq == KIND_ADD) begin
                  gx <= ad; gy <= bd; ph <= P_Q1;
                end else if (kq == KIND_MUL) begin
                  gx <= magf(an); gy <= bd; ph <= P_Q1;
                end else begin
                  rn <= an; rd <= ad; step_done <= 1'b1;
                end
              end
              P_Q1, P_Q3: begin
                // Shared gcd loop; P_Q1 gives g1, P_Q3 gives g2.
                if (gy == '0) begin
                  if (ph == P_Q1) begin
                    g1 <= gx;
                    if (kq == KIND_MUL) begin
                      gx <= magf(bn); gy <= ad; ph <= P_Q3;
                    end else begin
                      g2 <= gx; ph <= P_M1;
                    end
                  end else begin
                    g2 <= gx; ph <= P_M1;
                  end
                end else begin
                  dv_d <= gy; dv_q <= gx; dv_r <= '0;
                  dv_cnt <= CW'(W); dv_busy <= 1'b1;
                  ph <= (ph == P_Q1) ? P_Q2 : P_Q4;
                end
              end
              P_Q2, P_Q4: begin
                gx <= gy; gy <= dv_r;
                ph <= (ph == P_Q2) ? P_Q1 : P_Q3;
              end
              P_M1: begin
                // Reduce operands by g1/g2 (each a divider pass): both denominators for add, all four operands for mul.
                if (kq == KIND_MUL) begin
                  dv_d <= g1; dv_q <= magf(an);
                end else begin
                  dv_d <= g1; dv_q <= ad;
                end
                dv_r <= '0; dv_cnt <= CW'(W); dv_busy <= 1'b1;
                ph <= P_M2; gx <= '0;
              end
              P_M2: begin
                // gx counts reductions done: 0..3.
                unique case (gx[1:0])
                  2'd0: begin
                    adg <= dv_q;
                    dv_d <= (kq == KIND_MUL) ? g2 : g1;
                    dv_q <= (kq == KIND_MUL) ? magf(bn) : bd;
                  end
                  2'd1: begin
                    bdg <= dv_q;
                    dv_d <= (kq == KIND_MUL) ? g2 : g1;
                    dv_q <= ad;
                  end
                  2'd2: begin
                    t1 <= dv_q;
                    dv_d <= g1; dv_q <= bd;
                  end
                  default: begin
                    gy <= dv_q;
                  end
                endcase
                if (gx[1:0] != 2'd3 && !(kq != KIND_MUL && gx[1:0] == 2'd1)) begin
                  dv_r <= '0; dv_cnt <= CW'(W); dv_busy <= 1'b1;
                  gx <= gx + ONE;
                end else begin
                  ph <= P_M3; gx <= '0;
                end
              end
              P_M3: begin
                // Start products. For add: an*bdg, bn*adg, adg*bd.
                // For mul: (an/g1)*(bn/g2), (ad/g2)*(bd/g1).
                mu_acc <= '0; mu_cnt <= CW'(W); mu_busy <= 1'b1;
                unique case (gx[1:0])
                  2'd0: begin
                    if (kq == KIND_MUL) begin
                      mu_a <= adg; mu_b <= bdg; mu_neg <= an[W-1] ^ bn[W-1];
                    end else begin
                      mu_a <= magf(an); mu_b <= bdg; mu_neg <= an[W-1];
                    end
                  end
                  2'd1: begin
                    if (kq == KIND_MUL) begin
                      mu_a <= t1; mu_b <= gy; mu_neg <= 1'b0;
                    end else begin
                      mu_a <= magf(bn); mu_b <= adg; mu_neg <= bn[W-1];
                    end
                  end
                  default: begin
                    mu_a <= adg; mu_b <= bd; mu_neg <= 1'b0;
                  end
                endcase
                ph <= P_M4;
              end
              P_M4: begin
                if (mu_ovf) begin
                  stq <= ST_OVF; ph <= P_START; step_done <= 1'b1;
                end else begin
                  unique case (gx[1:0])
                    2'd0: begin
                      if (kq == KIND_MUL) rn <= mu_res; else t1 <= mu_res;
                      gx <= gx + ONE; ph <= P_M3;
                    end
                    2'd1: begin
                      if (kq == KIND_MUL) begin
                        rd <= mu_res; ph <= P_START; step_done <= 1'b1;
                      end else begin
                        ph <= P_ADD;
                      end
                    end
                    default: begin
                      rd <= mu_res; ph <= P_START; step_done <= 1'b1;
                    end
                  endcase
                end
              end
              P_ADD: begin
                if (sum[W] != sum[W-1]) begin
                  stq <= ST_OVF; ph <= P_START; step_done <= 1'b1;
                end else begin
                  rn <= sum[W-1:0]; gx <= W'(2); ph <= P_M3;
                end
              end
              default: ph <= P_START;
            endcase
          end
        endcase
      end
    end
  end

  assign st = stq;
  assign kind_q = kq;
  assign res_num = rn;
  assign res_den = rd;
endmodule

// ----- rtl/core/rau_ctrl.sv -----
// Controller of the rational arithmetic unit: sequences normalize, operate
// and normalize-result steps and runs the handshakes. Depends on rau_pkg.
`timescale 1ns / 1ps
module rau_ctrl import rau_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       load,
  output logic [3:0] step,
  output logic       step_go,
  input  logic       step_done,
  input  logic [1:0] st,
  input  logic [2:0] kind_q,
  output logic       cap
);
  typedef enum logic [5:0] {
    IDLE  = 6'b000001,
    NA    = 6'b000010,
    NB    = 6'b000100,
    OPER  = 6'b001000,
    NR    = 6'b010000,
    DONE  = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   ovalid;

  always_comb begin
    state_next = state;
    step = S_NORM_A;
    step_go = 1'b0;
    cap = 1'b0;
    unique case (state)
      IDLE: if (in_valid) state_next = NA;
      NA: begin
        step = S_NORM_A; step_go = 1'b1;
        if (step_done) begin
          if (st != ST_OK) state_next = DONE;
          else if (kind_q <= KIND_DIV) state_next = NB;
          else state_next = OPER;
        end
      end
      NB: begin
        step = S_NORM_B; step_go = 1'b1;
        if (step_done) state_next = (st != ST_OK) ? DONE : OPER;
      end
      OPER: begin
        step = S_OPER; step_go = 1'b1;
        if (step_done) state_next = (st != ST_OK || kind_q > KIND_NEG) ? DONE : NR;
      end
      NR: begin
        step = S_NORM_R; step_go = 1'b1;
        if (step_done) state_next = DONE;
      end
      DONE: if (!ovalid || !out_stall) begin
        cap = 1'b1; state_next = IDLE;
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      ovalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cap) ovalid <= 1'b1;
      else if (!out_stall) ovalid <= 1'b0;
    end
  end

  assign in_stall = (state != IDLE);
  assign load = (state == IDLE) && in_valid;
  assign out_valid = ovalid;
endmodule

// ----- rtl/core/rational_arith_unit.sv -----
// Rational arithmetic unit top level: controller, datapath and output
// register. Depends on rau_pkg, rau_ctrl and rau_datapath.
//
// One item at a time. How long an item takes is set by the operands: every
// gcd round and every reduction is a pass through one shared restoring
// divider, and every product is a pass through a shift-add multiplier.
// The input is stalled from the transfer of an item until its result has
// moved into the output register; a finished result waits there while the
// next item is accepted and worked on.
`timescale 1ns / 1ps
module rational_arith_unit import rau_pkg::*; #(
  parameter int unsigned WORD_BITS = WordBitsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  kind,
  input  logic [63:0] a_num,
  input  logic [63:0] a_den,
  input  logic [63:0] b_num,
  input  logic [62:0] b_den,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [63:0] result_num,
  output logic [62:0] result_den
);
  logic                 load, step_go, step_done, cap;
  logic [3:0]           step;
  logic [1:0]           st;
  logic [2:0]           kind_q;
  logic [WORD_BITS-1:0] rn, rd;

  rau_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
    .load, .step, .step_go, .step_done, .st, .kind_q, .cap
  );

  rau_datapath #(.WORD_BITS(WORD_BITS)) u_dp (
    .clk, .rst, .load, .kind, .a_num, .a_den, .b_num, .b_den,
    .step, .step_go, .step_done, .st, .kind_q, .res_num(rn), .res_den(rd)
  );

  always_ff @(posedge clk) begin
    if (cap) begin
      status <= st;
      if (st == ST_OK) begin
        result_num <= 64'(signed'(rn));
        result_den <= 63'(rd);
      end else begin
        result_num <= 64'd0;
        result_den <= 63'd1;
      end
    end
  end
endmodule

// ----- rtl/core/rau_checker.sv -----
// Port checker for the rational arithmetic unit, bound to the top level.
// Depends on rau_pkg.
`timescale 1ns / 1ps
module rau_checker import rau_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  status,
  input logic [63:0] result_num,
  input logic [62:0] result_den
);
  a_stat: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_DIV0 || status == ST_OVF))
    else $error("bad status");
  a_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> result_num == 64'd0 && result_den == 63'd1)
    else $error("error result not cleared");
  a_den: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OK |-> result_den != 63'd0)
    else $error("zero denominator");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result_num))
    else $error("stalled result changed");
  // One item at a time: an input transfer always closes the input.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input open right after a transfer");
endmodule

bind rational_arith_unit rau_checker u_chk (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
  .status, .result_num, .result_den
);
